[hw/rtl/per_class_packet_latency_stats_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef PER_CLASS_PACKET_LATENCY_STATS_MACROS_SVH
`define PER_CLASS_PACKET_LATENCY_STATS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/pcls_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pcls_pkg;

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned TS_W   = 48;
	localparam int unsigned LEN_W  = 17;
	localparam int unsigned CLS_W  = 3;
	localparam int unsigned BYTE_W = LEN_W - 3;
	localparam int unsigned DLY_W  = 40;
	localparam int unsigned PKT_W  = 48;
	localparam int unsigned BYT_W  = 56;
	localparam int unsigned SUM_W  = 60;

	localparam int unsigned IN_DATA_W  = 152;
	localparam int unsigned IN_USER_W  = 4;
	localparam int unsigned OUT_DATA_W = 536;
	localparam int unsigned OUT_USER_W = 1;

	localparam int unsigned CLASS_COUNT_DEF = 5;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// Classified descriptor handed from front to back.
	typedef struct packed {
		logic              acc;
		logic              cls_ok;
		logic [CLS_W-1:0]  cls;
		logic              marked;
		logic [BYTE_W-1:0] nbytes;
		logic [DLY_W-1:0]  delay;
	} job_t;

	// One statistics set (overall or per class).
	typedef struct packed {
		logic [PKT_W-1:0] packets;
		logic [BYT_W-1:0] nbytes;
		logic [SUM_W-1:0] dsum;
		logic [DLY_W-1:0] dmin;
		logic [DLY_W-1:0] dmax;
	} set_t;

	function automatic logic [PKT_W-1:0] sat_inc(input logic [PKT_W-1:0] a);
		return (&a) ? a : a + PKT_W'(1);
	endfunction

	function automatic logic [BYT_W-1:0] sat_add_bytes(input logic [BYT_W-1:0] a,
			input logic [BYTE_W-1:0] b);
		logic [BYT_W:0] s;
		s = {1'b0, a} + (BYT_W+1)'(b);
		return s[BYT_W] ? {BYT_W{1'b1}} : s[BYT_W-1:0];
	endfunction

	function automatic logic [SUM_W-1:0] sat_add_delay(input logic [SUM_W-1:0] a,
			input logic [DLY_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (SUM_W+1)'(b);
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

	function automatic set_t set_update(input set_t cur, input logic [BYTE_W-1:0] b,
			input logic [DLY_W-1:0] d);
		set_t nxt;
		logic first;
		first       = (cur.packets == '0);
		nxt.packets = sat_inc(cur.packets);
		nxt.nbytes  = sat_add_bytes(cur.nbytes, b);
		nxt.dsum    = sat_add_delay(cur.dsum, d);
		nxt.dmin    = (first || d < cur.dmin) ? d : cur.dmin;
		nxt.dmax    = (first || d > cur.dmax) ? d : cur.dmax;
		return nxt;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/pcls_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// Address match, delay and class check; one register stage.
module pcls_front #(
	parameter int unsigned CLASS_COUNT = pcls_pkg::CLASS_COUNT_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output      logic                           s_axis_tready,
	input  wire logic [pcls_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input  wire logic [pcls_pkg::IN_USER_W-1:0] s_axis_tuser,
	input  wire logic                           cfg_wen,
	input  wire logic [pcls_pkg::ADDR_W-1:0]    cfg_wdata,
	output      logic                           job_valid,
	output      pcls_pkg::job_t                 job,
	input  wire logic                           job_ready
);

	localparam int unsigned TW = pcls_pkg::TS_W;
	localparam int unsigned DW = pcls_pkg::DLY_W;
	localparam int unsigned CW = pcls_pkg::CLS_W;

	logic [pcls_pkg::ADDR_W-1:0] listen_q;
	logic                        vld_s1;
	pcls_pkg::job_t              job_s1;
	pcls_pkg::job_t              job_d;

	logic [pcls_pkg::ADDR_W-1:0] dest;
	logic [TW-1:0]               created;
	logic [TW-1:0]               arrived;
	logic [pcls_pkg::LEN_W-1:0]  len;
	logic [TW:0]                 diff;

	assign dest    = s_axis_tdata[31:0];
	assign created = s_axis_tdata[79:32];
	assign arrived = s_axis_tdata[127:80];
	assign len     = s_axis_tdata[144:128];

	always_comb begin
		diff          = {1'b0, arrived} - {1'b0, created};
		job_d.acc     = (listen_q == '0) || (dest == listen_q);
		job_d.cls     = s_axis_tuser[CW-1:0];
		job_d.cls_ok  = {1'b0, job_d.cls} < (CW+1)'(CLASS_COUNT);
		job_d.marked  = s_axis_tuser[CW];
		job_d.nbytes  = len[pcls_pkg::LEN_W-1:3];
		// negative delay clamps to zero, long delay saturates
		if (diff[TW]) begin
			job_d.delay = '0;
		end else if (|diff[TW-1:DW]) begin
			job_d.delay = {DW{1'b1}};
		end else begin
			job_d.delay = diff[DW-1:0];
		end
	end

	assign s_axis_tready = !vld_s1 || job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listen_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			if (cfg_wen) begin
				listen_q <= cfg_wdata;
			end
			if (s_axis_tready) begin
				vld_s1 <= s_axis_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			job_s1 <= job_d;
		end
	end

	assign job_valid = vld_s1;
	assign job       = job_s1;

endmodule
`default_nettype wire

[hw/rtl/pcls_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "per_class_packet_latency_stats_macros.svh"
// Small job queue; DEPTH is a power of two, at least 2.
module pcls_fifo #(
	parameter int unsigned DEPTH = pcls_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire pcls_pkg::job_t push_data,
	output      logic           full,
	input  wire logic           pop,
	output      pcls_pkg::job_t pop_data,
	output      logic           not_empty
);

	localparam int unsigned AW = $clog2(DEPTH);

	pcls_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW:0]    cnt_q;

	assign full      = (cnt_q == (AW+1)'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

	`PCLS_ASSERT_NOW(a_fifo_no_underflow, clk, arst_n, pop, not_empty, "pop on empty queue")
	`PCLS_ASSERT_NEXT(a_fifo_push_fills, clk, arst_n, push && !pop, not_empty, "push lost")

endmodule
`default_nettype wire

[hw/rtl/pcls_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "per_class_packet_latency_stats_macros.svh"
// Statistics update: one job per cycle while the output is not stalled; result held in the output register.
module pcls_back #(
	parameter int unsigned CLASS_COUNT = pcls_pkg::CLASS_COUNT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            job_valid,
	input  wire pcls_pkg::job_t                  job,
	output      logic                            job_ready,
	output      logic                            m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output      logic [pcls_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output      logic [pcls_pkg::OUT_USER_W-1:0] m_axis_tuser
);

	localparam int unsigned CW = pcls_pkg::CLS_W;

	pcls_pkg::set_t            all_q;
	pcls_pkg::set_t            cls_q   [CLASS_COUNT];
	logic [pcls_pkg::PKT_W-1:0] marks_q [CLASS_COUNT];

	pcls_pkg::set_t             all_nxt;
	pcls_pkg::set_t             cls_cur;
	pcls_pkg::set_t             cls_nxt;
	logic [pcls_pkg::PKT_W-1:0] marks_cur;
	logic [pcls_pkg::PKT_W-1:0] marks_nxt;
	logic                       pop;
	logic                       out_valid_q;
	logic [pcls_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                       out_acc_q;

	assign pop       = job_valid && (!out_valid_q || m_axis_tready);
	assign job_ready = pop;

	// pick the class entry; an invalid class reads as all zero
	always_comb begin
		cls_cur   = '0;
		marks_cur = '0;
		for (int c = 0; c < int'(CLASS_COUNT); c++) begin
			if (job.cls_ok && job.cls == CW'(c)) begin
				cls_cur   = cls_q[c];
				marks_cur = marks_q[c];
			end
		end
	end

	always_comb begin
		all_nxt   = job.acc ? pcls_pkg::set_update(all_q, job.nbytes, job.delay) : all_q;
		cls_nxt   = (job.acc && job.cls_ok) ?
			pcls_pkg::set_update(cls_cur, job.nbytes, job.delay) : cls_cur;
		marks_nxt = (job.acc && job.cls_ok && job.marked) ?
			pcls_pkg::sat_inc(marks_cur) : marks_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_q       <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < int'(CLASS_COUNT); c++) begin
				cls_q[c]   <= '0;
				marks_q[c] <= '0;
			end
		end else begin
			if (pop) begin
				all_q <= all_nxt;
				for (int c = 0; c < int'(CLASS_COUNT); c++) begin
					if (job.cls_ok && job.cls == CW'(c)) begin
						cls_q[c]   <= cls_nxt;
						marks_q[c] <= marks_nxt;
					end
				end
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_acc_q  <= job.acc;
			out_data_q <= {marks_nxt, cls_nxt.dmax, cls_nxt.dmin, cls_nxt.dsum,
				cls_nxt.nbytes, cls_nxt.packets, all_nxt.dmax, all_nxt.dmin,
				all_nxt.dsum, all_nxt.nbytes, all_nxt.packets};
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_acc_q;

	`PCLS_ASSERT_NOW(a_acc_counted, clk, arst_n, out_valid_q && out_acc_q,
		out_data_q[47:0] != '0, "accepted beat with zero packet count")
	`PCLS_ASSERT_NOW(a_min_le_max, clk, arst_n, out_valid_q,
		out_data_q[203:164] <= out_data_q[243:204], "overall min above max")

endmodule
`default_nettype wire

[hw/rtl/per_class_packet_latency_stats.sv]
`timescale 1ns / 1ps
`default_nettype none
// Per-class packet latency statistics.
// Input stream: one beat per delivered packet descriptor. Output stream: one
// beat per input beat, in order, carrying the accepted flag and the overall
// and per-class counters as they stand after that packet.
// cfg_wen/cfg_wdata load the listen address (zero matches every destination);
// write it only while no beats are in flight.
// Path from input accept to output tvalid: front register, queue, output
// register. Throughput: one beat per cycle while the receiver takes beats,
// set by the read-modify-write of the counter set in the back end.
// Reset clears the listen address and every counter, min and max to zero;
// no clearing pass is needed.
// When the receiver stalls, the output beat holds, the queue fills and the
// front end keeps taking beats until it is full, then drops s_axis_tready.
// Counters saturate at full scale; delays are clamped to zero when negative
// and to 2^40-1 ns when too long.
module per_class_packet_latency_stats #(
	parameter int unsigned CLASS_COUNT = pcls_pkg::CLASS_COUNT_DEF,
	parameter int unsigned QUEUE_DEPTH = pcls_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output      logic                            s_axis_tready,
	// dest_address, created_ns, arrived_ns, length_bits, zero pad
	input  wire logic [pcls_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// service_class, congestion_marked
	input  wire logic [pcls_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output      logic                            m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// total_packets, total_bytes, total_delay, least_delay, greatest_delay,
	// class_packets, class_bytes, class_delay, class_least, class_greatest,
	// class_marked
	output      logic [pcls_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// accepted
	output      logic [pcls_pkg::OUT_USER_W-1:0] m_axis_tuser,
	input  wire logic                            cfg_wen,
	input  wire logic [pcls_pkg::ADDR_W-1:0]     cfg_wdata
);

	// front -> queue
	logic           f_valid;
	pcls_pkg::job_t f_job;
	logic           q_full;
	// queue -> back
	logic           q_not_empty;
	pcls_pkg::job_t q_job;
	logic           b_pop;

	pcls_front #(
		.CLASS_COUNT(CLASS_COUNT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.job_valid    (f_valid),
		.job          (f_job),
		.job_ready    (!q_full)
	);

	// decouples the stats update from the classifier
	pcls_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_valid && !q_full),
		.push_data(f_job),
		.full     (q_full),
		.pop      (b_pop),
		.pop_data (q_job),
		.not_empty(q_not_empty)
	);

	pcls_back #(
		.CLASS_COUNT(CLASS_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (q_not_empty),
		.job          (q_job),
		.job_ready    (b_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned ADDR_W     = pcls_pkg::ADDR_W;
	localparam int unsigned TS_W       = pcls_pkg::TS_W;
	localparam int unsigned LEN_W      = pcls_pkg::LEN_W;
	localparam int unsigned CLS_W      = pcls_pkg::CLS_W;
	localparam int unsigned BYTE_W     = pcls_pkg::BYTE_W;
	localparam int unsigned DLY_W      = pcls_pkg::DLY_W;
	localparam int unsigned PKT_W      = pcls_pkg::PKT_W;
	localparam int unsigned BYT_W      = pcls_pkg::BYT_W;
	localparam int unsigned SUM_W      = pcls_pkg::SUM_W;
	localparam int unsigned IN_DATA_W  = pcls_pkg::IN_DATA_W;
	localparam int unsigned IN_USER_W  = pcls_pkg::IN_USER_W;
	localparam int unsigned OUT_DATA_W = pcls_pkg::OUT_DATA_W;
	localparam int unsigned OUT_USER_W = pcls_pkg::OUT_USER_W;

	localparam int unsigned CLASSES = pcls_pkg::CLASS_COUNT_DEF;
	localparam logic [63:0] DELAY_TOP = (64'd1 << DLY_W) - 64'd1;
	localparam logic [63:0] TS_TOP = (64'd1 << TS_W) - 64'd1;
	localparam logic [ADDR_W-1:0] WILDCARD = '0;
	localparam logic [ADDR_W-1:0] NODE_ADDR = 32'hA000_0001;
	localparam int unsigned HOLD_CYCLES = 200;
	localparam int unsigned CYCLE_LIMIT = 200000;

	// One delivered packet descriptor as it goes onto the input stream.
	typedef struct packed {
		logic [ADDR_W-1:0] dest;
		logic [TS_W-1:0]   created;
		logic [TS_W-1:0]   arrived;
		logic [LEN_W-1:0]  len;
		logic [CLS_W-1:0]  cls;
		logic              marked;
	} pkt_t;

	// Output tdata layout; the first field sits in the lowest bits, so the
	// packed struct lists fields from the top down.
	typedef struct packed {
		logic [PKT_W-1:0] c_marked;
		logic [DLY_W-1:0] c_hi;
		logic [DLY_W-1:0] c_lo;
		logic [SUM_W-1:0] c_dsum;
		logic [BYT_W-1:0] c_bytes;
		logic [PKT_W-1:0] c_count;
		logic [DLY_W-1:0] t_hi;
		logic [DLY_W-1:0] t_lo;
		logic [SUM_W-1:0] t_dsum;
		logic [BYT_W-1:0] t_bytes;
		logic [PKT_W-1:0] t_count;
	} stats_beat_t;

	typedef struct packed {
		logic        acc;
		stats_beat_t s;
	} expected_beat_t;

	// Running totals of one statistics set.
	typedef struct packed {
		logic [PKT_W-1:0] count;
		logic [BYT_W-1:0] bytes;
		logic [SUM_W-1:0] dsum;
		logic [DLY_W-1:0] lo;
		logic [DLY_W-1:0] hi;
	} tally_t;

	// Mirrors the counters of the block and holds the beats it owes us.
	class stats_tracker;
		logic [ADDR_W-1:0] listen;
		tally_t overall;
		tally_t by_class [CLASSES];
		logic [PKT_W-1:0] marks [CLASSES];
		expected_beat_t expected_beats [$];
		int unsigned fails;

		function new();
			listen = '0;
			overall = '0;
			foreach (by_class[i]) begin
				by_class[i] = '0;
				marks[i] = '0;
			end
			fails = 0;
		endfunction

		function void set_listen(logic [ADDR_W-1:0] addr);
			listen = addr;
		endfunction

		function int unsigned pending();
			return expected_beats.size();
		endfunction

		// Operands stay below 2^61, so the 64-bit sum never wraps.
		static function logic [63:0] sat(logic [63:0] a, logic [63:0] b, int unsigned w);
			logic [63:0] top;
			top = (64'd1 << w) - 64'd1;
			return (a + b > top) ? top : a + b;
		endfunction

		static function tally_t fold(tally_t t, logic [BYTE_W-1:0] nb, logic [DLY_W-1:0] d);
			logic first;
			first = (t.count == '0);
			t.count = PKT_W'(sat(64'(t.count), 64'd1, PKT_W));
			t.bytes = BYT_W'(sat(64'(t.bytes), 64'(nb), BYT_W));
			t.dsum = SUM_W'(sat(64'(t.dsum), 64'(d), SUM_W));
			if (first || d < t.lo) t.lo = d;
			if (first || d > t.hi) t.hi = d;
			return t;
		endfunction

		function void note_packet(pkt_t p);
			logic [63:0] span;
			logic [DLY_W-1:0] d;
			logic hit;
			logic cls_ok;
			expected_beat_t e;
			hit = (listen == WILDCARD) || (p.dest == listen);
			cls_ok = (p.cls < CLASSES);
			span = (p.arrived >= p.created) ? 64'(p.arrived) - 64'(p.created) : 64'd0;
			d = (span > DELAY_TOP) ? DELAY_TOP[DLY_W-1:0] : span[DLY_W-1:0];
			if (hit) begin
				overall = fold(overall, p.len[LEN_W-1:3], d);
				if (cls_ok) begin
					by_class[p.cls] = fold(by_class[p.cls], p.len[LEN_W-1:3], d);
					if (p.marked)
						marks[p.cls] = PKT_W'(sat(64'(marks[p.cls]), 64'd1, PKT_W));
				end
			end
			e = '0;
			e.acc = hit;
			e.s.t_count = overall.count;
			e.s.t_bytes = overall.bytes;
			e.s.t_dsum = overall.dsum;
			e.s.t_lo = overall.lo;
			e.s.t_hi = overall.hi;
			if (cls_ok) begin
				e.s.c_count = by_class[p.cls].count;
				e.s.c_bytes = by_class[p.cls].bytes;
				e.s.c_dsum = by_class[p.cls].dsum;
				e.s.c_lo = by_class[p.cls].lo;
				e.s.c_hi = by_class[p.cls].hi;
				e.s.c_marked = marks[p.cls];
			end
			expected_beats.push_back(e);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
				fails++;
			end
		endfunction

		function void check_beat(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
			stats_beat_t got;
			expected_beat_t e;
			got = data;
			if (expected_beats.size() == 0) begin
				$error("output beat with no packet outstanding");
				fails++;
				return;
			end
			e = expected_beats.pop_front();
			compare_field("accepted", 64'(e.acc), 64'(user[0]));
			compare_field("total_packets", 64'(e.s.t_count), 64'(got.t_count));
			compare_field("total_bytes", 64'(e.s.t_bytes), 64'(got.t_bytes));
			compare_field("total_delay", 64'(e.s.t_dsum), 64'(got.t_dsum));
			compare_field("least_delay", 64'(e.s.t_lo), 64'(got.t_lo));
			compare_field("greatest_delay", 64'(e.s.t_hi), 64'(got.t_hi));
			compare_field("class_packets", 64'(e.s.c_count), 64'(got.c_count));
			compare_field("class_bytes", 64'(e.s.c_bytes), 64'(got.c_bytes));
			compare_field("class_delay", 64'(e.s.c_dsum), 64'(got.c_dsum));
			compare_field("class_least", 64'(e.s.c_lo), 64'(got.c_lo));
			compare_field("class_greatest", 64'(e.s.c_hi), 64'(got.c_hi));
			compare_field("class_marked", 64'(e.s.c_marked), 64'(got.c_marked));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic [IN_USER_W-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic cfg_wen;
	logic [ADDR_W-1:0] cfg_wdata;

	// calm: no idling on either side. hold_req: receiver starts a long hold-off.
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int unsigned cycle_count = 0;

	stats_tracker tracker = new();

	per_class_packet_latency_stats #(
		.CLASS_COUNT(CLASSES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("per_class_packet_latency_stats test failed");
		$finish;
	end

	// Receiver: checks every output beat, stalls at random, and once per run
	// holds tready low so the block backs up into its input.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				tracker.check_beat(m_axis_tdata, m_axis_tuser);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(99) >= 12);
			end
		end
	end

	function automatic pkt_t make_pkt(logic [ADDR_W-1:0] dest, logic [63:0] created,
			logic [63:0] arrived, logic [LEN_W-1:0] len, logic [CLS_W-1:0] cls,
			logic marked);
		pkt_t p;
		p.dest = dest;
		p.created = created[TS_W-1:0];
		p.arrived = arrived[TS_W-1:0];
		p.len = len;
		p.cls = cls;
		p.marked = marked;
		return p;
	endfunction

	// Half the packets aim at the listen address and most have sane delays; the
	// rest are misses, negative delays, delays around the clamp and raw timestamps.
	function automatic pkt_t random_packet(logic [ADDR_W-1:0] addr);
		pkt_t p;
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick < 5 && addr != WILDCARD) p.dest = addr;
		else if (pick == 5) p.dest = '0;
		else if (pick == 6) p.dest = '1;
		else p.dest = $urandom;
		p.created = TS_W'({$urandom, $urandom});
		pick = $urandom_range(9);
		if (pick < 6)
			p.arrived = p.created + TS_W'($urandom_range(0, 100000));
		else if (pick == 6)
			p.arrived = TS_W'(64'(p.created) + DELAY_TOP - 64'd1 + 64'($urandom_range(0, 3)));
		else if (pick == 7)
			p.arrived = p.created - TS_W'($urandom_range(1, 100000));
		else if (pick == 8)
			p.arrived = TS_W'({$urandom, $urandom});
		else
			p.arrived = p.created;
		pick = $urandom_range(19);
		if (pick == 0) p.len = '0;
		else if (pick == 1) p.len = '1;
		else p.len = LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
		p.cls = CLS_W'($urandom_range(0, (1 << CLS_W) - 1));
		p.marked = 1'($urandom_range(0, 1));
		return p;
	endfunction

	// Offer one beat and hold it until the block takes it. Gaps go in front
	// of the beat, so tvalid never drops and rises within one edge.
	task automatic send_packet(pkt_t p);
		while (!calm && $urandom_range(99) < 12) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_DATA_W'({p.len, p.arrived, p.created, p.dest});
		s_axis_tuser <= {p.marked, p.cls};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		tracker.note_packet(p);
	endtask

	// Wait until every outstanding beat is back, plus the pipeline depth.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// The listen address may only change with nothing in flight.
	task automatic write_listen(logic [ADDR_W-1:0] addr);
		drain();
		cfg_wen <= 1'b1;
		cfg_wdata <= addr;
		@(posedge clk);
		cfg_wen <= 1'b0;
		tracker.set_listen(addr);
	endtask

	task automatic send_random(int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_packet(random_packet(tracker.listen));
	endtask

	initial begin
		logic [ADDR_W-1:0] addr;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		cfg_wen <= 1'b0;
		cfg_wdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, wildcard listen address straight out of reset.
		send_packet(make_pkt('0, 64'd0, 64'd0, '0, 3'd0, 1'b0));   // zero delay, first packet
		send_packet(make_pkt('1, 64'd1000, 64'd400, 17'd7, 3'd0, 1'b1)); // negative, < 1 byte
		send_packet(make_pkt(32'h1234_5678, 64'd0, TS_TOP, '1, 3'd1, 1'b1)); // clamp, max len
		send_packet(make_pkt(32'd5, 64'd10, 64'd10 + DELAY_TOP, 17'd8, 3'd2, 1'b0)); // full scale
		send_packet(make_pkt(32'd5, 64'd10, 64'd11 + DELAY_TOP, 17'd9, 3'd2, 1'b1)); // one past
		send_packet(make_pkt(32'd6, TS_TOP, TS_TOP, 17'd100, 3'd3, 1'b0));
		send_packet(make_pkt(32'd7, 64'd100, 64'd150, 17'd800, 3'd4, 1'b1));
		send_packet(make_pkt(32'd7, 64'd100, 64'd120, 17'd800, 3'd4, 1'b0)); // new class min
		send_packet(make_pkt(32'd7, 64'd100, 64'd300, 17'd800, 3'd4, 1'b1)); // new class max
		send_packet(make_pkt(32'd8, 64'd50, 64'd60, 17'd64, 3'd5, 1'b1));    // invalid classes
		send_packet(make_pkt(32'd9, 64'd50, 64'd60, 17'd64, 3'd6, 1'b0));
		send_packet(make_pkt(32'd9, 64'd50, 64'd70, 17'd64, 3'd7, 1'b1));
		send_packet(make_pkt(32'd10, 64'd0, 64'd3, 17'd16, 3'd0, 1'b1));

		// Directed, one node address: hits, near misses, and a zero
		// destination that must not act as a wildcard.
		write_listen(NODE_ADDR);
		send_packet(make_pkt('0, 64'd0, 64'd5, 17'd8, 3'd1, 1'b1));
		send_packet(make_pkt(NODE_ADDR ^ 32'h1, 64'd0, 64'd5, 17'd8, 3'd1, 1'b1));
		send_packet(make_pkt(NODE_ADDR, 64'd0, 64'd5, 17'd8, 3'd1, 1'b1));
		send_packet(make_pkt(NODE_ADDR, 64'd0, 64'd2, 17'd8, 3'd5, 1'b1));
		send_packet(make_pkt('1, 64'd0, 64'd2, 17'd8, 3'd1, 1'b0));

		// Random phases across the listen address extremes.
		write_listen('1);
		send_random(300);

		write_listen(WILDCARD);
		calm = 1'b1;
		send_random(300);
		calm = 1'b0;

		do addr = $urandom; while (addr == WILDCARD);
		write_listen(addr);
		hold_req = 1'b1;
		send_random(350);

		do addr = $urandom; while (addr == WILDCARD);
		write_listen(addr);
		send_random(330);

		drain();
		repeat (8) @(posedge clk);
		if (tracker.fails == 0 && tracker.pending() == 0)
			$display("per_class_packet_latency_stats test passed");
		else
			$display("per_class_packet_latency_stats test failed");
		$finish;
	end

endmodule
